/* hdl/wmmcs_pkg.sv */
// Shared types and constants for the waveform min/max column scroller.
// No dependencies; imported by every module of the block.
package wmmcs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIN_CNT_W  = 16;
  localparam int AMP_W      = 7;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COL_OUT_W  = 9;
  localparam int ROW_OUT_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_PERCENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_WAVEFORM = 3'd1;

  localparam logic [WIN_CNT_W-1:0] WINDOW_RESET = 16'd512;
  localparam int                   AMP_RESET    = 70;
  localparam logic [AMP_W-1:0]     AMP_FULL     = 7'd100;
  localparam logic [MODE_W-1:0]    MODE_RESET   = MODE_WAVEFORM;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 199728
  localparam int              RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_25 = 18'd167773;
  localparam int              RECIP_SHIFT = 22;

  typedef struct packed {
    logic [WIN_CNT_W-1:0] window_samples;
    logic                 waveform;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] win_min;
    logic signed [SAMPLE_W-1:0] win_max;
    logic [COL_OUT_W-1:0]       column_addr;
    logic [COL_OUT_W-1:0]       scroll_start;
  } win_t;

endpackage

/* hdl/waveform_min_max_column_scroller.sv */
// Top level of the waveform min/max column scroller.
// Instantiates wmmcs_cfg, wmmcs_accum and wmmcs_rowmap; uses wmmcs_pkg.
//
// Keeps the minimum and maximum of the current window of signed 16-bit
// samples. The sample that fills the window closes it; in waveform mode the
// block then advances the scroll pointer and passes one beat through the
// accumulator and row mapper registers, with the column to redraw, the new
// scroll start and the screen rows of the window extremes. Throughput is one
// sample per clock while ready, set by the accumulator's compare-and-update;
// samples keep flowing while a result waits. Configuration writes take effect
// at once; the user must issue them while idle, unenforced by the block. An
// amplitude write computes the row scale and offset in the write cycle.
module waveform_min_max_column_scroller #(
  parameter int SCREEN_COLUMNS = 320,
  parameter int SCREEN_ROWS    = 240
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wmmcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wmmcs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [wmmcs_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [wmmcs_pkg::COL_OUT_W-1:0]      column_addr_o,
  output logic [wmmcs_pkg::COL_OUT_W-1:0]      scroll_start_o,
  output logic [wmmcs_pkg::ROW_OUT_W-1:0]      low_row_o,
  output logic [wmmcs_pkg::ROW_OUT_W-1:0]      high_row_o
);
  import wmmcs_pkg::*;

  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);

  cfg_t             cfg;
  logic [ROW_W-1:0] usable, offset;
  logic             win_valid, win_ready;
  win_t             win;

  wmmcs_cfg #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .ROW_W       (ROW_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .usable_o    (usable),
    .offset_o    (offset)
  );

  wmmcs_accum #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .COL_W          (COL_W)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .win_valid_o    (win_valid),
    .win_ready_i    (win_ready),
    .win_o          (win)
  );

  wmmcs_rowmap #(
    .ROW_W (ROW_W)
  ) u_rowmap (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .usable_i       (usable),
    .offset_i       (offset),
    .win_valid_i    (win_valid),
    .win_ready_o    (win_ready),
    .win_i          (win),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .column_addr_o  (column_addr_o),
    .scroll_start_o (scroll_start_o),
    .low_row_o      (low_row_o),
    .high_row_o     (high_row_o)
  );

endmodule

/* hdl/wmmcs_cfg.sv */
// Configuration registers: window length, display mode, and the row scale
// and offset derived from the amplitude percent at write time. Uses wmmcs_pkg.
module wmmcs_cfg #(
  parameter int SCREEN_ROWS = 240,
  parameter int ROW_W       = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmmcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wmmcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output wmmcs_pkg::cfg_t               cfg_o,
  output logic [ROW_W-1:0]              usable_o,
  output logic [ROW_W-1:0]              offset_o
);
  import wmmcs_pkg::*;

  localparam int PROD_W = ROW_W + AMP_W;
  localparam int X_W    = PROD_W - 2;
  localparam int R_W    = X_W + RECIP_W;
  localparam int RST_USABLE_I = SCREEN_ROWS * AMP_RESET / 100;
  localparam logic [ROW_W-1:0] RST_USABLE = ROW_W'(RST_USABLE_I);
  localparam logic [ROW_W-1:0] RST_OFFSET = ROW_W'((SCREEN_ROWS - RST_USABLE_I) / 2);

  logic [WIN_CNT_W-1:0] window_q;
  logic [MODE_W-1:0]    mode_q;
  logic [ROW_W-1:0]     usable_q, usable_d;
  logic [ROW_W-1:0]     offset_q, offset_d;

  logic [AMP_W-1:0]  amp;
  logic [PROD_W-1:0] prod;
  logic [X_W-1:0]    quarter;
  logic [R_W-1:0]    recip;

  // usable = rows * amp / 100, taken as (rows * amp / 4) / 25
  always_comb begin
    amp      = (cfg_wdata_i[AMP_W-1:0] > AMP_FULL) ? AMP_FULL : cfg_wdata_i[AMP_W-1:0];
    prod     = PROD_W'(SCREEN_ROWS) * PROD_W'(amp);
    quarter  = prod[PROD_W-1:2];
    recip    = R_W'(quarter) * R_W'(RECIP_25);
    usable_d = recip[RECIP_SHIFT +: ROW_W];
    offset_d = (ROW_W'(SCREEN_ROWS) - usable_d) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      mode_q   <= MODE_RESET;
      usable_q <= RST_USABLE;
      offset_q <= RST_OFFSET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SAMPLES: window_q <= cfg_wdata_i[WIN_CNT_W-1:0];
        CFG_AMPLITUDE_PERCENT: begin
          usable_q <= usable_d;
          offset_q <= offset_d;
        end
        CFG_DISPLAY_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.window_samples = window_q;
  assign cfg_o.waveform       = (mode_q == MODE_WAVEFORM);
  assign usable_o             = usable_q;
  assign offset_o             = offset_q;

endmodule

/* hdl/wmmcs_accum.sv */
// Window accumulator: tracks min, max and count per sample and, in waveform mode,
// advances the scroll pointer on a closed window and registers its beat. Uses wmmcs_pkg.
module wmmcs_accum #(
  parameter int SCREEN_COLUMNS = 320,
  parameter int COL_W          = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wmmcs_pkg::cfg_t                    cfg_i,
  input  logic                               sample_valid_i,
  output logic                               sample_ready_o,
  input  logic signed [wmmcs_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               win_valid_o,
  input  logic                               win_ready_i,
  output wmmcs_pkg::win_t                    win_o
);
  import wmmcs_pkg::*;

  logic signed [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic [WIN_CNT_W-1:0]       cnt_q, cnt_d, cnt_inc, limit;
  logic [COL_W-1:0]           pos_q, pos_d, pos_inc;
  logic                       valid_q, valid_d;
  logic                       accept, close, emit;
  logic [31:0]                col_ext, start_ext;
  win_t                       win_q, win_d;

  assign sample_ready_o = !valid_q || win_ready_i;
  assign accept         = sample_valid_i && sample_ready_o;

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    limit   = (cfg_i.window_samples == '0) ? WIN_CNT_W'(1) : cfg_i.window_samples;
    cnt_inc = cnt_q + WIN_CNT_W'(1);
    close   = (cnt_inc == '0) || (cnt_inc >= limit);
    emit    = accept && close && cfg_i.waveform;
    pos_inc = (pos_q == COL_W'(SCREEN_COLUMNS - 1)) ? '0 : pos_q + COL_W'(1);
    if (accept) begin
      if (close) begin
        min_d = SAMPLE_MAX;
        max_d = SAMPLE_MIN;
        cnt_d = '0;
        if (cfg_i.waveform) begin
          pos_d = pos_inc;
        end
      end else begin
        min_d = (sample_i < min_q) ? sample_i : min_q;
        max_d = (sample_i > max_q) ? sample_i : max_q;
        cnt_d = cnt_inc;
      end
    end
  end

  always_comb begin
    col_ext            = 32'(pos_q);
    start_ext          = 32'(pos_inc);
    win_d.win_min      = (sample_i < min_q) ? sample_i : min_q;
    win_d.win_max      = (sample_i > max_q) ? sample_i : max_q;
    win_d.column_addr  = col_ext[COL_OUT_W-1:0];
    win_d.scroll_start = start_ext[COL_OUT_W-1:0];
  end

  always_comb begin
    if (emit) begin
      valid_d = 1'b1;
    end else if (win_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= SAMPLE_MAX;
      max_q   <= SAMPLE_MIN;
      cnt_q   <= '0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      min_q   <= min_d;
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      win_q <= win_d;
    end
  end

  assign win_valid_o = valid_q;
  assign win_o       = win_q;

endmodule

/* hdl/wmmcs_rowmap.sv */
// Row mapper: scales the window extremes to screen rows and holds the
// result beat in the output register. Uses wmmcs_pkg.
module wmmcs_rowmap #(
  parameter int ROW_W = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ROW_W-1:0]                    usable_i,
  input  logic [ROW_W-1:0]                    offset_i,
  input  logic                                win_valid_i,
  output logic                                win_ready_o,
  input  wmmcs_pkg::win_t                     win_i,
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output logic [wmmcs_pkg::COL_OUT_W-1:0]     column_addr_o,
  output logic [wmmcs_pkg::COL_OUT_W-1:0]     scroll_start_o,
  output logic [wmmcs_pkg::ROW_OUT_W-1:0]     low_row_o,
  output logic [wmmcs_pkg::ROW_OUT_W-1:0]     high_row_o
);
  import wmmcs_pkg::*;

  localparam int Y_W = SAMPLE_W + ROW_W;

  // row = (s + 32768) * usable / 65535 + offset; divide via y + (y >> 16) + 1
  function automatic logic [ROW_W:0] to_row(input logic signed [SAMPLE_W-1:0] s,
                                            input logic [ROW_W-1:0] usable,
                                            input logic [ROW_W-1:0] offset);
    logic [SAMPLE_W-1:0] biased;
    logic [Y_W-1:0]      y;
    logic [Y_W:0]        acc;
    biased = {~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
    y      = Y_W'(biased) * Y_W'(usable);
    acc    = (Y_W+1)'(y) + (Y_W+1)'(y >> SAMPLE_W) + (Y_W+1)'(1);
    return (ROW_W+1)'(acc >> SAMPLE_W) + (ROW_W+1)'(offset);
  endfunction

  logic                 valid_q, valid_d, accept;
  logic [ROW_W:0]       low_full, high_full;
  logic [31:0]          low_ext, high_ext;
  logic [COL_OUT_W-1:0] col_q, start_q;
  logic [ROW_OUT_W-1:0] low_q, low_d, high_q, high_d;

  assign win_ready_o = !valid_q || result_ready_i;
  assign accept      = win_valid_i && win_ready_o;

  always_comb begin
    low_full  = to_row(win_i.win_min, usable_i, offset_i);
    high_full = to_row(win_i.win_max, usable_i, offset_i);
    low_ext   = 32'(low_full);
    high_ext  = 32'(high_full);
    low_d     = low_ext[ROW_OUT_W-1:0];
    high_d    = high_ext[ROW_OUT_W-1:0];
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (result_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= win_i.column_addr;
      start_q <= win_i.scroll_start;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  assign result_valid_o = valid_q;
  assign column_addr_o  = col_q;
  assign scroll_start_o = start_q;
  assign low_row_o      = low_q;
  assign high_row_o     = high_q;

endmodule

/* hdl/wmmcs_checker.sv */
// Port-level checker for the waveform min/max column scroller, bound to the
// top level. Uses wmmcs_pkg for port widths.
module wmmcs_checker #(
  parameter int SCREEN_COLUMNS = 320,
  parameter int SCREEN_ROWS    = 240
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             result_valid_o,
  input logic                             result_ready_i,
  input logic [wmmcs_pkg::COL_OUT_W-1:0]  column_addr_o,
  input logic [wmmcs_pkg::COL_OUT_W-1:0]  scroll_start_o,
  input logic [wmmcs_pkg::ROW_OUT_W-1:0]  low_row_o,
  input logic [wmmcs_pkg::ROW_OUT_W-1:0]  high_row_o
);
  import wmmcs_pkg::*;

  localparam bit COLS_FIT = (SCREEN_COLUMNS <= 512);
  localparam bit ROWS_FIT = (SCREEN_ROWS <= 255);
  localparam logic [COL_OUT_W-1:0] LAST_COL = COL_OUT_W'(SCREEN_COLUMNS - 1);

  logic                 beat;
  logic [COL_OUT_W-1:0] last_start_q;

  assign beat = result_valid_o && result_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_start_q <= '0;
    end else if (beat) begin
      last_start_q <= scroll_start_o;
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o)
    else $error("result beat dropped while stalled");

  a_start_follows_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && COLS_FIT |->
      scroll_start_o == ((column_addr_o == LAST_COL) ? '0 : column_addr_o + COL_OUT_W'(1)))
    else $error("scroll start not one column past redraw column");

  a_col_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> column_addr_o == last_start_q)
    else $error("redraw column does not continue from last scroll start");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ROWS_FIT |->
      low_row_o <= high_row_o && high_row_o <= ROW_OUT_W'(SCREEN_ROWS))
    else $error("row of window minimum above row of maximum or off screen");

endmodule

bind waveform_min_max_column_scroller wmmcs_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .column_addr_o  (column_addr_o),
  .scroll_start_o (scroll_start_o),
  .low_row_o      (low_row_o),
  .high_row_o     (high_row_o)
);
